/* design/iso_timestamp_text_to_epoch_core_defines.svh */
// ----------------------------------------------------------------------------
// iso timestamp text to epoch: assertion macros
// concurrent check helpers, empty bodies under synthesis
// ----------------------------------------------------------------------------
`ifndef ISO_TIMESTAMP_TEXT_TO_EPOCH_CORE_DEFINES_SVH
`define ISO_TIMESTAMP_TEXT_TO_EPOCH_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ITTE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ITTE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ITTE_ASSERT_IMP(lbl, ante, cons, msg)
`define ITTE_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* design/itte_pkg.sv */
// ----------------------------------------------------------------------------
// itte_pkg
// shared types, constants and helpers of the timestamp text parser
// ----------------------------------------------------------------------------
package itte_pkg;

  localparam int unsigned VALUE_W = 59;
  localparam int unsigned DAYS_W  = 24;
  localparam int unsigned TOT_W   = 42;

  // text positions
  localparam logic [4:0] DATE_LEN = 5'd10;
  localparam logic [4:0] TIME_END = 5'd19;
  localparam logic [4:0] FRAC_END = 5'd26;
  localparam logic [4:0] POS_MAX  = 5'd31;

  // digit masks, bit i is the i-th position of the field
  localparam logic [9:0] DATE_PAT = 10'b11_0110_1111;
  localparam logic [8:0] TIME_PAT = 9'b1_1011_0110;
  localparam logic [6:0] FRAC_PAT = 7'b111_1110;

  localparam logic [7:0] DOT_CHAR  = 8'h2E;
  localparam logic [7:0] ZERO_CHAR = 8'h30;
  localparam logic [7:0] NINE_CHAR = 8'h39;

  // arithmetic constants
  localparam logic [11:0]       RECIP25     = 12'd2622;   // ceil(2^16 / 25)
  localparam logic [13:0]       RECIP5      = 14'd13108;  // ceil(2^16 / 5)
  localparam logic [23:0]       DAY_OFFSET  = 24'd865565; // 146097 + 719468
  localparam logic signed [17:0] SEC_PER_DAY = 18'sd86400;
  localparam logic signed [20:0] US_PER_SEC  = 21'sd1000000;

  typedef enum logic [2:0] {
    STEP_PREP  = 3'd0,
    STEP_QUOT  = 3'd1,
    STEP_DAYS  = 3'd2,
    STEP_SECS  = 3'd3,
    STEP_MULLO = 3'd4,
    STEP_MULHI = 3'd5
  } calc_step_e;

  typedef struct packed {
    logic       take_char;
    logic       take_last;
    logic       step_en;
    calc_step_e step;
    logic       load_out;
  } itte_cmd_t;

  // x * 10 + d, low bits kept
  function automatic logic [19:0] dec_step(logic [19:0] x, logic [3:0] d);
    logic [19:0] r;
    r = 20'({x, 3'b000} + {x, 1'b0} + {16'b0, d});
    return r;
  endfunction

  function automatic logic pat_ok(logic need_digit, logic is_digit, logic [7:0] c);
    logic r;
    r = need_digit ? is_digit : (!is_digit && (c != 8'h00));
    return r;
  endfunction

endpackage

/* design/itte_char_if.sv */
// ----------------------------------------------------------------------------
// itte_char_if
// text byte channel: one character per request
// ----------------------------------------------------------------------------
interface itte_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last_char;
  logic       null_marker;

  modport source (output valid, output character, output last_char,
                  output null_marker, input ready);
  modport sink   (input valid, input character, input last_char,
                  input null_marker, output ready);
endinterface

/* design/itte_result_if.sv */
// ----------------------------------------------------------------------------
// itte_result_if
// result channel: epoch value and flags
// ----------------------------------------------------------------------------
interface itte_result_if import itte_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] time_value;
  logic                      null_flag;
  logic                      date_valid;
  logic                      time_added;
  logic                      fraction_added;

  modport source (output valid, output time_value, output null_flag,
                  output date_valid, output time_added, output fraction_added,
                  input ready);
  modport sink   (input valid, input time_value, input null_flag,
                  input date_valid, input time_added, input fraction_added,
                  output ready);
endinterface

/* design/itte_cfg_if.sv */
// ----------------------------------------------------------------------------
// itte_cfg_if
// configuration write channel for the with_time register
// ----------------------------------------------------------------------------
interface itte_cfg_if;
  logic valid;
  logic ready;
  logic with_time;

  modport source (output valid, output with_time, input ready);
  modport sink   (input valid, input with_time, output ready);
endinterface

/* design/iso_timestamp_text_to_epoch_core.sv */
// ----------------------------------------------------------------------------
// iso_timestamp_text_to_epoch_core
// ISO date / timestamp text to epoch days or microseconds
// ----------------------------------------------------------------------------
// usage
//   char_i carries the text one byte per request, first byte first; last_char
//   closes the text and null_marker on that byte marks an SQL null
//   result_o carries one request per text: time_value plus four flags
//   cfg_i writes with_time (0: day count, 1: microseconds); it is always ready
//   and is meant to be written only while no text is in flight
// throughput
//   one byte per cycle while a text streams in; after the last byte char_i
//   drops ready for the six arithmetic steps of the shared datapath and the
//   output load, which waits until the output register is free
// result
//   the output load puts the result on result_o after the arithmetic steps
// stall
//   a waiting result sits in the output register; bytes of the next text are
//   taken meanwhile, and its last byte holds the sequencer until the register
//   frees up
// reset
//   clears the sequencer and the digit gatherers, with_time comes up as 1
// ----------------------------------------------------------------------------
`include "iso_timestamp_text_to_epoch_core_defines.svh"

module iso_timestamp_text_to_epoch_core import itte_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  itte_char_if.sink  char_i,
  itte_result_if.source result_o,
  itte_cfg_if.sink   cfg_i
);

  itte_cmd_t cmd;

  // config writes go straight into a register, never back-pressured
  assign cfg_i.ready = 1'b1;

  // sequencer: owns both handshakes and steps the arithmetic
  itte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (char_i.valid),
    .in_last_i   (char_i.last_char),
    .out_ready_i (result_o.ready),
    .in_ready_o  (char_i.ready),
    .out_valid_o (result_o.valid),
    .cmd_o       (cmd)
  );

  // datapath: digit gathering, pattern checks, day and microsecond math
  itte_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .character_i      (char_i.character),
    .null_marker_i    (char_i.null_marker),
    .cfg_we_i         (cfg_i.valid),
    .cfg_with_time_i  (cfg_i.with_time),
    .time_value_o     (result_o.time_value),
    .null_flag_o      (result_o.null_flag),
    .date_valid_o     (result_o.date_valid),
    .time_added_o     (result_o.time_added),
    .fraction_added_o (result_o.fraction_added)
  );

  // ---------------- checks ----------------
  // the last byte of a text starts the arithmetic, so intake must pause
  `ITTE_ASSERT_NXT(a_last_pauses_intake, char_i.valid && char_i.ready && char_i.last_char, !char_i.ready, "intake still open after last byte")
  // a rejected or null text reports zero
  `ITTE_ASSERT_IMP(a_invalid_is_zero, result_o.valid && !result_o.date_valid, result_o.time_value == '0, "nonzero value without a valid date")
  // flags nest: fraction needs time, time needs date
  `ITTE_ASSERT_IMP(a_flags_nest, result_o.valid, (!result_o.fraction_added || result_o.time_added) && (!result_o.time_added || result_o.date_valid), "result flags out of order")
  // a null text carries no other flag
  `ITTE_ASSERT_IMP(a_null_alone, result_o.valid && result_o.null_flag, !result_o.date_valid, "null result marked as a valid date")

endmodule

/* design/itte_datapath.sv */
// ----------------------------------------------------------------------------
// itte_datapath
// digit gathering, pattern checks and multi-cycle epoch arithmetic
// ----------------------------------------------------------------------------
module itte_datapath import itte_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  itte_cmd_t                 cmd_i,
  input  logic [7:0]                character_i,
  input  logic                      null_marker_i,
  input  logic                      cfg_we_i,
  input  logic                      cfg_with_time_i,
  output logic signed [VALUE_W-1:0] time_value_o,
  output logic                      null_flag_o,
  output logic                      date_valid_o,
  output logic                      time_added_o,
  output logic                      fraction_added_o
);

  logic        with_time_q;
  logic [4:0]  pos_q, pos_d;
  logic [13:0] year_q, year_d;
  logic [6:0]  month_q, month_d, day_q, day_d;
  logic [6:0]  hour_q, hour_d, minute_q, minute_d, second_q, second_d;
  logic [19:0] frac_q, frac_d;
  logic [2:0]  flags_q, flags_d;
  logic        date_ok_q, date_ok_d, time_ok_q, time_ok_d, frac_ok_q, frac_ok_d;
  logic        null_q, null_d;

  logic        is_dig;
  logic [3:0]  dv;
  logic [4:0]  tsub, fsub;
  logic [19:0] step_res;

  // arithmetic registers
  logic [13:0]              yy_q;
  logic [14:0]              mpt_q;
  logic [18:0]              secs_q;
  logic [7:0]               q100_q;
  logic [5:0]               q400_q;
  logic [12:0]              doyb_q;
  logic signed [DAYS_W-1:0] days_q;
  logic signed [TOT_W-1:0]  tot_q;
  logic [VALUE_W-1:0]       acc_q;

  logic                     le2;
  logic [6:0]               mp;
  logic [23:0]              p100, p400;
  logic [28:0]              pdoy;
  logic [23:0]              days_sum;
  logic signed [TOT_W-1:0]  days_ext;
  logic signed [TOT_W-1:0]  dsec;
  logic [40:0]              lo_prod;
  logic signed [41:0]       hi_prod;

  // ---------------- character intake ----------------
  assign is_dig = (character_i >= ZERO_CHAR) && (character_i <= NINE_CHAR);
  assign dv     = is_dig ? character_i[3:0] : 4'd0;
  assign tsub   = pos_q - DATE_LEN;
  assign fsub   = pos_q - TIME_END;

  always_comb begin
    pos_d     = pos_q;
    year_d    = year_q;
    month_d   = month_q;
    day_d     = day_q;
    hour_d    = hour_q;
    minute_d  = minute_q;
    second_d  = second_q;
    frac_d    = frac_q;
    flags_d   = flags_q;
    date_ok_d = date_ok_q;
    time_ok_d = time_ok_q;
    frac_ok_d = frac_ok_q;
    null_d    = null_q;
    step_res  = '0;
    if (cmd_i.take_char) begin
      if (pos_q < DATE_LEN) begin
        if (!pat_ok(DATE_PAT[pos_q[3:0]], is_dig, character_i)) flags_d[0] = 1'b1;
        case (pos_q)
          5'd0, 5'd1, 5'd2, 5'd3: begin
            step_res = dec_step({6'b0, year_q}, dv);
            year_d   = step_res[13:0];
          end
          5'd5, 5'd6: begin
            step_res = dec_step({13'b0, month_q}, dv);
            month_d  = step_res[6:0];
          end
          5'd8, 5'd9: begin
            step_res = dec_step({13'b0, day_q}, dv);
            day_d    = step_res[6:0];
          end
          default: ;
        endcase
      end else if (pos_q < TIME_END) begin
        if (!pat_ok(TIME_PAT[tsub[3:0]], is_dig, character_i)) flags_d[1] = 1'b1;
        case (pos_q)
          5'd11, 5'd12: begin
            step_res = dec_step({13'b0, hour_q}, dv);
            hour_d   = step_res[6:0];
          end
          5'd14, 5'd15: begin
            step_res = dec_step({13'b0, minute_q}, dv);
            minute_d = step_res[6:0];
          end
          5'd17, 5'd18: begin
            step_res = dec_step({13'b0, second_q}, dv);
            second_d = step_res[6:0];
          end
          default: ;
        endcase
      end else if (pos_q < FRAC_END) begin
        if (pos_q == TIME_END) begin
          if (character_i != DOT_CHAR) flags_d[2] = 1'b1;
        end else begin
          if (!pat_ok(FRAC_PAT[fsub[2:0]], is_dig, character_i)) flags_d[2] = 1'b1;
          frac_d = dec_step(frac_q, dv);
        end
      end
      pos_d = (pos_q == POS_MAX) ? pos_q : 5'(pos_q + 5'd1);
    end
    if (cmd_i.take_last) begin
      null_d    = null_marker_i;
      date_ok_d = !null_marker_i && (pos_d >= DATE_LEN) && !flags_d[0];
      time_ok_d = date_ok_d && with_time_q && (pos_d >= TIME_END) && !flags_d[1];
      frac_ok_d = time_ok_d && (pos_d >= FRAC_END) && !flags_d[2];
    end
    if (cmd_i.load_out) begin
      pos_d    = '0;
      year_d   = '0;
      month_d  = '0;
      day_d    = '0;
      hour_d   = '0;
      minute_d = '0;
      second_d = '0;
      frac_d   = '0;
      flags_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      with_time_q <= 1'b1;
      pos_q       <= '0;
      year_q      <= '0;
      month_q     <= '0;
      day_q       <= '0;
      hour_q      <= '0;
      minute_q    <= '0;
      second_q    <= '0;
      frac_q      <= '0;
      flags_q     <= '0;
      date_ok_q   <= 1'b0;
      time_ok_q   <= 1'b0;
      frac_ok_q   <= 1'b0;
      null_q      <= 1'b0;
    end else begin
      if (cfg_we_i) with_time_q <= cfg_with_time_i;
      pos_q     <= pos_d;
      year_q    <= year_d;
      month_q   <= month_d;
      day_q     <= day_d;
      hour_q    <= hour_d;
      minute_q  <= minute_d;
      second_q  <= second_d;
      frac_q    <= frac_d;
      flags_q   <= flags_d;
      date_ok_q <= date_ok_d;
      time_ok_q <= time_ok_d;
      frac_ok_q <= frac_ok_d;
      null_q    <= null_d;
    end
  end

  // ---------------- epoch arithmetic ----------------
  assign le2 = (month_q <= 7'd2);
  assign mp  = le2 ? 7'(month_q + 7'd9) : 7'(month_q - 7'd3);

  // divide by 100 and 400 through a reciprocal of 25, by 5 likewise
  assign p100 = {12'b0, yy_q[13:2]} * {12'b0, RECIP25};
  assign p400 = {14'b0, yy_q[13:4]} * {12'b0, RECIP25};
  assign pdoy = {14'b0, mpt_q} * {15'b0, RECIP5};

  assign days_sum = 24'({10'b0, yy_q} * 24'd365 + {12'b0, yy_q[13:2]}
                        + {18'b0, q400_q} + {11'b0, doyb_q} + {17'b0, day_q}
                        - {16'b0, q100_q} - 24'd1 - DAY_OFFSET);

  // day count widened first so the seconds product keeps its top bits
  assign days_ext = {{(TOT_W-DAYS_W){days_q[DAYS_W-1]}}, days_q};
  assign dsec     = days_ext * TOT_W'(SEC_PER_DAY) + $signed({23'b0, secs_q});
  assign lo_prod  = {20'b0, tot_q[20:0]} * {21'b0, US_PER_SEC[19:0]};
  assign hi_prod  = $signed(tot_q[TOT_W-1:21]) * US_PER_SEC;

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_en) begin
      case (cmd_i.step)
        STEP_PREP: begin
          yy_q   <= 14'(year_q + 14'd400 - {13'b0, le2});
          mpt_q  <= 15'({8'b0, mp} * 15'd153 + 15'd2);
          secs_q <= time_ok_q ? 19'({12'b0, hour_q} * 19'd3600 + {12'b0, minute_q} * 19'd60
                                    + {12'b0, second_q}) : 19'd0;
        end
        STEP_QUOT: begin
          q100_q <= p100[23:16];
          q400_q <= p400[21:16];
          doyb_q <= pdoy[28:16];
        end
        STEP_DAYS:  days_q <= $signed(days_sum);
        STEP_SECS:  tot_q  <= dsec;
        STEP_MULLO: acc_q  <= VALUE_W'(lo_prod) + (frac_ok_q ? {39'b0, frac_q} : '0);
        STEP_MULHI: acc_q  <= acc_q + {hi_prod[37:0], 21'b0};
        default: ;
      endcase
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (!date_ok_q)       time_value_o <= '0;
      else if (with_time_q) time_value_o <= $signed(acc_q);
      else                  time_value_o <= {{(VALUE_W-DAYS_W){days_q[DAYS_W-1]}}, days_q};
      null_flag_o      <= null_q;
      date_valid_o     <= date_ok_q;
      time_added_o     <= time_ok_q;
      fraction_added_o <= frac_ok_q;
    end
  end

endmodule

/* design/itte_ctrl.sv */
// ----------------------------------------------------------------------------
// itte_ctrl
// sequencer: byte intake, arithmetic steps, result hand-off
// ----------------------------------------------------------------------------
module itte_ctrl import itte_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_last_i,
  input  logic      out_ready_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output itte_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_HOLD = 3'b100
  } state_e;

  state_e     state_q, state_d;
  calc_step_e step_q, step_d;
  logic       out_valid_q, out_valid_d;
  logic       take;

  assign in_ready_o = (state_q == ST_IDLE);
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    state_d         = state_q;
    step_d          = step_q;
    cmd_o.take_char = take;
    cmd_o.take_last = take && in_last_i;
    cmd_o.step_en   = 1'b0;
    cmd_o.step      = step_q;
    cmd_o.load_out  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (take && in_last_i) begin
          state_d = ST_CALC;
          step_d  = STEP_PREP;
        end
      end
      ST_CALC: begin
        cmd_o.step_en = 1'b1;
        case (step_q)
          STEP_PREP:  step_d = STEP_QUOT;
          STEP_QUOT:  step_d = STEP_DAYS;
          STEP_DAYS:  step_d = STEP_SECS;
          STEP_SECS:  step_d = STEP_MULLO;
          STEP_MULLO: step_d = STEP_MULHI;
          default:    state_d = ST_HOLD;
        endcase
      end
      ST_HOLD: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out)   out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else                  out_valid_d = out_valid_q;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_PREP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* dv/itte_epoch_watch.sv */
// ----------------------------------------------------------------------------
// itte_epoch_watch
// follows the text byte and config channels, works out the epoch value and
// flags of every closed text, and compares them with the result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itte_epoch_watch import itte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  itte_char_if        char_i,
  itte_result_if      result_i,
  itte_cfg_if         cfg_i,
  output int unsigned mismatches_o,
  output int unsigned awaited_o,
  output int unsigned results_o,
  output int unsigned dated_o,
  output int unsigned timed_o,
  output int unsigned fractioned_o,
  output int unsigned nulled_o
);

  typedef struct packed {
    logic signed [VALUE_W-1:0] time_value;
    logic                      null_flag;
    logic                      date_valid;
    logic                      time_added;
    logic                      fraction_added;
  } epoch_result_t;

  epoch_result_t epoch_due_q[$];

  logic        mode_us;
  logic [4:0]  text_pos;
  logic [13:0] year_acc;
  logic [6:0]  month_acc, day_acc, hour_acc, minute_acc, second_acc;
  logic [19:0] frac_acc;
  logic [2:0]  fault_bits; // date, time, fraction

  // proleptic calendar, march-based year, shifted by one era to stay positive
  function automatic longint days_since_epoch(longint y, longint m, longint d);
    longint y_adj, era, yoe, mar_month, doy, doe;
    y_adj     = y + 400 - ((m <= 2) ? 1 : 0);
    era       = y_adj / 400;
    yoe       = y_adj % 400;
    mar_month = (m > 2) ? m - 3 : m + 9;
    doy       = (153 * mar_month + 2) / 5 + d - 1;
    doe       = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return (era - 1) * 146097 + doe - 719468;
  endfunction

  task automatic clear_text();
    text_pos   = '0;
    year_acc   = '0;
    month_acc  = '0;
    day_acc    = '0;
    hour_acc   = '0;
    minute_acc = '0;
    second_acc = '0;
    frac_acc   = '0;
    fault_bits = '0;
  endtask

  task automatic absorb_byte(logic [7:0] c, logic last, logic nul);
    logic          is_dig, sep_ok, date_ok, time_ok, frac_ok;
    logic [19:0]   digit;
    int unsigned   p;
    longint        v;
    epoch_result_t due;
    is_dig = (c >= ZERO_CHAR) && (c <= NINE_CHAR);
    sep_ok = !is_dig && (c != 8'h00);
    digit  = is_dig ? 20'(c - ZERO_CHAR) : '0;
    p      = text_pos;
    if (p < DATE_LEN) begin
      if (!(DATE_PAT[p] ? is_dig : sep_ok)) fault_bits[0] = 1'b1;
      if (p <= 3) year_acc = 14'(year_acc * 10 + digit);
      else if (p == 5 || p == 6) month_acc = 7'(month_acc * 10 + digit);
      else if (p == 8 || p == 9) day_acc = 7'(day_acc * 10 + digit);
    end else if (p < TIME_END) begin
      if (!(TIME_PAT[p - DATE_LEN] ? is_dig : sep_ok)) fault_bits[1] = 1'b1;
      if (p == 11 || p == 12) hour_acc = 7'(hour_acc * 10 + digit);
      else if (p == 14 || p == 15) minute_acc = 7'(minute_acc * 10 + digit);
      else if (p == 17 || p == 18) second_acc = 7'(second_acc * 10 + digit);
    end else if (p < FRAC_END) begin
      if (p == TIME_END) begin
        if (c != DOT_CHAR) fault_bits[2] = 1'b1;
      end else begin
        if (!(FRAC_PAT[p - TIME_END] ? is_dig : sep_ok)) fault_bits[2] = 1'b1;
        frac_acc = 20'(frac_acc * 10 + digit);
      end
    end
    text_pos = (text_pos == POS_MAX) ? POS_MAX : text_pos + 5'd1;

    if (last) begin
      date_ok = !nul && (text_pos >= DATE_LEN) && !fault_bits[0];
      time_ok = date_ok && mode_us && (text_pos >= TIME_END) && !fault_bits[1];
      frac_ok = time_ok && (text_pos >= FRAC_END) && !fault_bits[2];
      v = 0;
      if (date_ok) begin
        v = days_since_epoch(longint'(year_acc), longint'(month_acc), longint'(day_acc));
        if (mode_us) begin
          v = v * 64'sd86400000000;
          if (time_ok)
            v += ((longint'(hour_acc) * 60 + longint'(minute_acc)) * 60
                  + longint'(second_acc)) * 1000000;
          if (frac_ok) v += longint'(frac_acc);
        end
      end
      due.time_value     = v[VALUE_W-1:0];
      due.null_flag      = nul;
      due.date_valid     = date_ok;
      due.time_added     = time_ok;
      due.fraction_added = frac_ok;
      epoch_due_q.push_back(due);
      clear_text();
    end
  endtask

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    epoch_result_t due;
    if (!rst_ni) begin
      mode_us = 1'b1;
      clear_text();
      epoch_due_q.delete();
      mismatches_o = 0;
      results_o    = 0;
      dated_o      = 0;
      timed_o      = 0;
      fractioned_o = 0;
      nulled_o     = 0;
    end else begin
      if (result_i.valid && result_i.ready) begin
        results_o++;
        if (epoch_due_q.size() == 0) begin
          $error("result request with no text closed: time_value %0d",
                 longint'(result_i.time_value));
          mismatches_o++;
        end else begin
          due = epoch_due_q.pop_front();
          compare_field("time_value", longint'(due.time_value),
                        longint'(result_i.time_value));
          compare_field("null_flag", due.null_flag, result_i.null_flag);
          compare_field("date_valid", due.date_valid, result_i.date_valid);
          compare_field("time_added", due.time_added, result_i.time_added);
          compare_field("fraction_added", due.fraction_added, result_i.fraction_added);
          dated_o      += due.date_valid;
          timed_o      += due.time_added;
          fractioned_o += due.fraction_added;
          nulled_o     += due.null_flag;
        end
      end
      if (cfg_i.valid && cfg_i.ready) mode_us = cfg_i.with_time;
      if (char_i.valid && char_i.ready)
        absorb_byte(char_i.character, char_i.last_char, char_i.null_marker);
    end
    awaited_o = epoch_due_q.size();
  end

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// feeds iso date and timestamp texts into the parser byte by byte, in day
// count and microsecond mode, with bursty sending and result back-pressure;
// a watcher beside the block predicts and checks every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import itte_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 2000; // cycles with no request at all
  localparam int unsigned HOLD_CYCLES   = 300;  // long result stall
  localparam int unsigned SETTLE_CYCLES = 12;   // extra wait once no result is awaited
  localparam int unsigned TOTAL_BYTES   = 500;  // byte requests for the whole run

  logic clk;
  logic rst_n;

  itte_char_if   char_w ();
  itte_result_if res_w ();
  itte_cfg_if    cfg_w ();

  int unsigned mismatches, awaited, results, dated, timed, fractioned, nulled;

  iso_timestamp_text_to_epoch_core u_top (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .char_i   (char_w),
    .result_o (res_w),
    .cfg_i    (cfg_w)
  );

  itte_epoch_watch u_epoch_watch (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .char_i       (char_w),
    .result_i     (res_w),
    .cfg_i        (cfg_w),
    .mismatches_o (mismatches),
    .awaited_o    (awaited),
    .results_o    (results),
    .dated_o      (dated),
    .timed_o      (timed),
    .fractioned_o (fractioned),
    .nulled_o     (nulled)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // text under construction, first byte at index 0
  logic [7:0]  text_q[$];
  int unsigned burst_left;
  int unsigned bytes_sent;
  int unsigned texts_sent;
  bit          hold_results; // asks the receiver for one long stall

  // --------------------------------------------------------------------------
  // receiver: stall pattern changes at random between always ready, coin
  // flip and mostly stalled; one long hold-off on demand
  // --------------------------------------------------------------------------
  initial begin : result_drain
    int unsigned mode_left;
    int unsigned mode;
    mode_left = 0;
    mode = 0;
    res_w.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        res_w.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          0:       res_w.ready <= 1'b1;
          1:       res_w.ready <= 1'($urandom_range(0, 1));
          default: res_w.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: nothing moving on any channel for too long ends the run
  // --------------------------------------------------------------------------
  int unsigned idle_cycles;
  always @(posedge clk) begin
    if (!rst_n || (char_w.valid && char_w.ready) || (res_w.valid && res_w.ready)
        || (cfg_w.valid && cfg_w.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("iso_timestamp_text_to_epoch_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------

  // one byte request; bursts of random length with random gaps between them
  task automatic push_char(logic [7:0] c, logic last, logic nul);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        char_w.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    char_w.valid       <= 1'b1;
    char_w.character   <= c;
    char_w.last_char   <= last;
    char_w.null_marker <= nul;
    do @(posedge clk); while (!char_w.ready);
    bytes_sent++;
  endtask

  // null marker is meaningful on the closing byte only, noise elsewhere
  task automatic send_text(logic nul);
    int unsigned last_idx;
    last_idx = text_q.size() - 1;
    foreach (text_q[i]) begin
      if (i == last_idx) push_char(text_q[i], 1'b1, nul);
      else push_char(text_q[i], 1'b0, $urandom_range(0, 7) == 0);
    end
    texts_sent++;
  endtask

  task automatic put_number(int unsigned v, int unsigned ndig);
    int unsigned scale;
    scale = 1;
    repeat (ndig - 1) scale *= 10;
    repeat (ndig) begin
      text_q.push_back(ZERO_CHAR + 8'((v / scale) % 10));
      scale /= 10;
    end
  endtask

  // canonical "YYYY-MM-DDTHH:MM:SS.ffffff" cut or padded to len bytes;
  // padding is stray digits and zone-like punctuation
  task automatic compose_stamp(int unsigned yr, int unsigned mon, int unsigned dy,
                               int unsigned hr, int unsigned mn, int unsigned sc,
                               int unsigned frac, int unsigned len);
    text_q.delete();
    put_number(yr, 4);
    text_q.push_back("-");
    put_number(mon, 2);
    text_q.push_back("-");
    put_number(dy, 2);
    text_q.push_back("T");
    put_number(hr, 2);
    text_q.push_back(":");
    put_number(mn, 2);
    text_q.push_back(":");
    put_number(sc, 2);
    text_q.push_back(DOT_CHAR);
    put_number(frac, 6);
    while (text_q.size() < len)
      text_q.push_back($urandom_range(0, 2) != 0 ? ZERO_CHAR + 8'($urandom_range(0, 9))
                                                  : 8'(":"));
    while (text_q.size() > len) void'(text_q.pop_back());
  endtask

  // mostly well-formed stamps with random content and length, the rest
  // carries odd separators, corrupted bytes or plain noise
  task automatic send_random_text();
    int unsigned shape, len, hits, idx;
    int unsigned yr, mon, dy, hr, mn, sc, frac;
    logic [7:0]  c;
    yr   = $urandom_range(0, 9999);
    mon  = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 12) : $urandom_range(0, 99);
    dy   = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 31) : $urandom_range(0, 99);
    hr   = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 23) : $urandom_range(0, 99);
    mn   = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 59) : $urandom_range(0, 99);
    sc   = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 59) : $urandom_range(0, 99);
    frac = $urandom_range(0, 999999);
    case ($urandom_range(0, 5))
      0:       len = 10;
      1:       len = 19;
      2, 3:    len = 26;
      4:       len = $urandom_range(27, 40);
      default: len = $urandom_range(1, 26);
    endcase
    compose_stamp(yr, mon, dy, hr, mn, sc, frac, len);
    shape = $urandom_range(0, 99);
    if (shape < 30) begin
      // any byte that is neither a digit nor zero may separate fields
      foreach (text_q[i]) begin
        if (i == 4 || i == 7 || i == 10 || i == 13 || i == 16) begin
          do c = 8'($urandom_range(1, 255)); while (c >= ZERO_CHAR && c <= NINE_CHAR);
          text_q[i] = c;
        end
      end
    end else if (shape >= 70 && shape < 88) begin
      hits = $urandom_range(1, 2);
      repeat (hits) begin
        idx = $urandom_range(0, text_q.size() - 1);
        text_q[idx] = 8'($urandom_range(0, 255));
      end
    end else if (shape >= 88) begin
      text_q.delete();
      repeat ($urandom_range(1, 34)) text_q.push_back(8'($urandom_range(0, 255)));
    end
    send_text($urandom_range(0, 9) == 0);
  endtask

  // stop sending, wait until every result has come, then a further settle wait
  task automatic settle();
    char_w.valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_mode(logic use_us);
    cfg_w.valid     <= 1'b1;
    cfg_w.with_time <= use_us;
    do @(posedge clk); while (!cfg_w.ready);
    cfg_w.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_n              = 1'b0;
    char_w.valid       = 1'b0;
    char_w.character   = '0;
    char_w.last_char   = 1'b0;
    char_w.null_marker = 1'b0;
    cfg_w.valid        = 1'b0;
    cfg_w.with_time    = 1'b1;
    hold_results       = 1'b0;
    burst_left         = 0;
    bytes_sent         = 0;
    texts_sent         = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed texts, microsecond mode out of reset
    compose_stamp(1970, 1, 1, 0, 0, 0, 0, 10);               // epoch, date only
    send_text(1'b0);
    compose_stamp(1970, 1, 1, 0, 0, 0, 0, 19);               // time, no fraction
    send_text(1'b0);
    compose_stamp(9999, 12, 31, 23, 59, 59, 999999, 26);     // top of range
    send_text(1'b0);
    compose_stamp(0, 1, 1, 0, 0, 0, 0, 26);                  // bottom, space sep
    text_q[10] = " ";
    send_text(1'b0);
    compose_stamp(2000, 2, 29, 12, 34, 56, 123456, 38);      // extra bytes saturate
    send_text(1'b0);
    compose_stamp(2024, 6, 15, 8, 0, 0, 0, 10);              // null value
    send_text(1'b1);
    compose_stamp(2023, 99, 99, 99, 99, 99, 0, 26);          // fields past range
    send_text(1'b0);
    compose_stamp(2023, 0, 0, 0, 0, 0, 0, 26);               // month and day zero
    send_text(1'b0);
    compose_stamp(2023, 5, 5, 0, 0, 0, 0, 9);                // one byte short
    send_text(1'b0);
    text_q.delete();                                         // lone zero byte
    text_q.push_back(8'h00);
    send_text(1'b0);
    compose_stamp(2024, 3, 3, 1, 2, 3, 4, 26);               // digit as date sep
    text_q[4] = "5";
    send_text(1'b0);
    compose_stamp(2024, 3, 3, 1, 2, 3, 4, 26);               // zero byte as date sep
    text_q[7] = 8'h00;
    send_text(1'b0);
    compose_stamp(2024, 3, 3, 1, 2, 3, 4, 26);               // letter in hour
    text_q[12] = "a";
    send_text(1'b0);
    compose_stamp(2024, 3, 3, 1, 2, 3, 4, 26);               // zero byte as time sep
    text_q[13] = 8'h00;
    send_text(1'b0);
    compose_stamp(2024, 3, 3, 1, 2, 3, 4, 26);               // comma instead of dot
    text_q[19] = ",";
    send_text(1'b0);
    compose_stamp(2024, 3, 3, 1, 2, 3, 4, 25);               // five fraction digits
    send_text(1'b0);
    compose_stamp(2024, 3, 3, 1, 2, 3, 4, 26);               // bad fraction digit
    text_q[22] = 8'hFF;
    send_text(1'b0);
    compose_stamp(2024, 3, 3, 1, 2, 3, 4, 26);               // zero byte in year
    text_q[0] = 8'h00;
    send_text(1'b0);
    settle();

    // directed texts, day count mode
    write_mode(1'b0);
    compose_stamp(2024, 2, 29, 13, 14, 15, 161718, 26);
    send_text(1'b0);
    compose_stamp(1969, 12, 31, 0, 0, 0, 0, 10);
    send_text(1'b0);
    compose_stamp(2024, 2, 29, 13, 14, 15, 161718, 26);
    send_text(1'b1);

    // random texts in day count mode
    repeat (2) send_random_text();
    settle();

    // results held back for a long stretch while texts keep coming
    write_mode(1'b1);
    hold_results = 1'b1;
    repeat (3) send_random_text();
    settle();

    // top up to the byte budget in microsecond mode
    while (bytes_sent < TOTAL_BYTES)
      send_random_text();
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (awaited != 0) begin
      $error("%0d results never arrived", awaited);
    end
    $display("run covered %0d texts in %0d byte requests, %0d results in both modes",
             texts_sent, bytes_sent, results);
    $display("valid dates %0d, with time %0d, with fraction %0d, null %0d",
             dated, timed, fractioned, nulled);
    if (mismatches == 0 && awaited == 0) begin
      $display("iso_timestamp_text_to_epoch_core: match");
    end else begin
      $display("iso_timestamp_text_to_epoch_core: mismatch");
    end
    $finish;
  end

endmodule
